FILE: sv/baro_comp_pkg.sv
// ----------------------------------------------------------------------------
// baro_comp_pkg
// types, constants and the control program of the pressure compensation block
// ----------------------------------------------------------------------------
package baro_comp_pkg;

  // calibration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_C1 = 3'd0;  // pressure sensitivity
  localparam logic [CfgIdxW-1:0] REG_C2 = 3'd1;  // pressure offset
  localparam logic [CfgIdxW-1:0] REG_C3 = 3'd2;  // sensitivity temperature coefficient
  localparam logic [CfgIdxW-1:0] REG_C4 = 3'd3;  // offset temperature coefficient
  localparam logic [CfgIdxW-1:0] REG_C5 = 3'd4;  // reference temperature
  localparam logic [CfgIdxW-1:0] REG_C6 = 3'd5;  // temperature coefficient

  // datapath widths
  localparam int unsigned RawW   = 24;
  localparam int unsigned CalW   = 16;
  localparam int unsigned DtW    = 25;
  localparam int unsigned MulBW  = 19;
  localparam int unsigned ProdW  = DtW + MulBW;  // 44
  localparam int unsigned TempW  = 21;
  localparam int unsigned HeldW  = 15;
  localparam int unsigned OffW   = 37;
  localparam int unsigned SensW  = 36;
  localparam int unsigned AccW   = 62;
  localparam int unsigned OutW   = 32;
  localparam int unsigned SensLoW = 17;

  // temperature constants, hundredths of a degree
  localparam logic signed [TempW-1:0] TEMP_BASE = 21'sd2000;
  localparam logic signed [TempW-1:0] WIN_LO    = -21'sd3000;
  localparam logic signed [TempW-1:0] WIN_HI    = 21'sd10000;

  // program step counter
  localparam int unsigned StepW = 4;
  typedef logic [StepW-1:0] step_t;
  localparam step_t STEP_WAIT = 4'd0;
  localparam step_t STEP_OUT  = 4'd9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DT,      // dt = d2 - c5 * 256
    OP_TEMP,    // temp = 2000 + prod >> 23, window check
    OP_OFF,     // off = c2 * 2^16 + prod >> 7
    OP_SENS,    // sens = c1 * 2^15 + prod >> 8
    OP_ACC_LO,  // acc = prod
    OP_ACC_HI,  // acc += prod << 17
    OP_OUT      // pressure = (acc >> 21 - off) >> 15, load result register
  } alu_op_e;

  typedef enum logic {
    MA_DT,
    MA_D1
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_C6,
    MB_C4,
    MB_C3,
    MB_SLO,
    MB_SHI
  } mul_b_e;

  typedef enum logic [1:0] {
    COND_NEVER,     // fall through
    COND_NO_IN,     // jump while no input request
    COND_OUT_BUSY,  // jump while the result register is full and not taken
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    alu_op_e alu;
    logic    mul_en;
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    cond_e   cond;
    step_t   target;
    logic    last;
  } ctl_t;

  function automatic ctl_t ctl_rom(step_t step);
    ctl_t w;
    w = '{alu: OP_NONE, mul_en: 1'b0, mul_a: MA_DT, mul_b: MB_C6,
          cond: COND_NEVER, target: STEP_WAIT, last: 1'b0};
    case (step)
      4'd0: begin w.cond = COND_NO_IN; w.target = STEP_WAIT; end
      4'd1: w.alu = OP_DT;
      4'd2: begin w.mul_en = 1'b1; w.mul_a = MA_DT; w.mul_b = MB_C6; end
      4'd3: begin
        w.alu = OP_TEMP; w.mul_en = 1'b1; w.mul_a = MA_DT; w.mul_b = MB_C4;
      end
      4'd4: begin
        w.alu = OP_OFF; w.mul_en = 1'b1; w.mul_a = MA_DT; w.mul_b = MB_C3;
      end
      4'd5: w.alu = OP_SENS;
      4'd6: begin w.mul_en = 1'b1; w.mul_a = MA_D1; w.mul_b = MB_SLO; end
      4'd7: begin
        w.alu = OP_ACC_LO; w.mul_en = 1'b1; w.mul_a = MA_D1; w.mul_b = MB_SHI;
      end
      4'd8: w.alu = OP_ACC_HI;
      4'd9: begin
        w.alu = OP_OUT; w.cond = COND_OUT_BUSY; w.target = STEP_OUT; w.last = 1'b1;
      end
      default: begin w.cond = COND_ALWAYS; w.target = STEP_WAIT; end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// first-order temperature compensation of raw barometer conversions
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | raw pressure, raw temperature
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | temp, held temp, pressure
//  cfg       | in        | cfg_valid_i/cfg_ready_o      | register index, 16-bit word
//
//  a request passes through an accept step and nine microcode steps, which
//  share the single 25x19 multiplier and its registered product
//  the input side is ready only at the wait step; the result register lets
//  the next request start while the last result is still waiting
//  a full result register that is not taken holds the sequencer at its final step
//  reset clears the sequencer, the result valid, calibration and held temp
//
module baro_sensor_compensation
  import baro_comp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [47:0]        s_axis_tdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [31:0] temp_centi, [46:32] held_temp_centi, [78:47] pressure_pa, [79] zero
  output logic [79:0]        m_axis_tdata,
  // [0] temp_accepted
  output logic               m_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CalW-1:0]    cfg_data_i
);

  // calibration words
  logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  // sequencer
  step_t step_q, step_d;
  ctl_t  ctl;
  logic  in_fire, out_busy, out_load, cond_hit;

  // datapath registers
  logic [RawW-1:0]          d1_q, d2_q;
  logic signed [DtW-1:0]    dt_q, dt_d;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [TempW-1:0]  temp_q, temp_d;
  logic                     ok_q, ok_d;
  logic signed [HeldW-1:0]  held_q;
  logic signed [OffW-1:0]   off_q, off_d;
  logic signed [SensW-1:0]  sens_q, sens_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [DtW-1:0]    mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [41:0]       press_diff;

  // result register
  logic                     out_valid_q;
  logic signed [OutW-1:0]   out_temp_q;
  logic signed [HeldW-1:0]  out_held_q;
  logic                     out_ok_q;
  logic signed [OutW-1:0]   out_press_q;

  // configuration: always ready, unknown indexes ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_C1:  c1_q <= cfg_data_i;
        REG_C2:  c2_q <= cfg_data_i;
        REG_C3:  c3_q <= cfg_data_i;
        REG_C4:  c4_q <= cfg_data_i;
        REG_C5:  c5_q <= cfg_data_i;
        REG_C6:  c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control word for the current step
  assign ctl = ctl_rom(step_q);

  assign s_axis_tready = (ctl.cond == COND_NO_IN);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign out_load      = (ctl.alu == OP_OUT) && !out_busy;

  always_comb begin
    case (ctl.cond)
      COND_NO_IN:    cond_hit = !in_fire;
      COND_OUT_BUSY: cond_hit = out_busy;
      COND_ALWAYS:   cond_hit = 1'b1;
      default:       cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      step_d = ctl.target;
    end else if (ctl.last) begin
      step_d = STEP_WAIT;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  // shared multiplier operands
  always_comb begin
    case (ctl.mul_a)
      MA_D1:   mul_a = $signed({1'b0, d1_q});
      default: mul_a = dt_q;
    endcase
    case (ctl.mul_b)
      MB_C6:   mul_b = $signed({3'b000, c6_q});
      MB_C4:   mul_b = $signed({3'b000, c4_q});
      MB_C3:   mul_b = $signed({3'b000, c3_q});
      MB_SLO:  mul_b = $signed({2'b00, sens_q[SensLoW-1:0]});
      MB_SHI:  mul_b = sens_q[SensW-1:SensLoW];
      default: mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // alu results, each taken only at its own step
  assign dt_d   = $signed({1'b0, d2_q}) - $signed({1'b0, c5_q, 8'h00});
  assign temp_d = $signed(prod_q[ProdW-1:23]) + TEMP_BASE;
  assign ok_d   = (temp_d > WIN_LO) && (temp_d < WIN_HI);
  assign off_d  = $signed({5'b00000, c2_q, 16'h0000}) + $signed(prod_q[ProdW-1:7]);
  assign sens_d = $signed({5'b00000, c1_q, 15'h0000}) + $signed(prod_q[ProdW-1:8]);

  always_comb begin
    case (ctl.alu)
      OP_ACC_LO: acc_d = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
      OP_ACC_HI: acc_d = acc_q + $signed({prod_q[ProdW-1], prod_q, 17'h00000});
      default:   acc_d = acc_q;
    endcase
  end

  // floor of acc / 2^21 minus offset; the final / 2^15 is the part-select
  assign press_diff = $signed({acc_q[AccW-1], acc_q[AccW-1:21]})
                    - $signed({{(42-OffW){off_q[OffW-1]}}, off_q});

  // sequencer, held temperature and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_WAIT;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if ((ctl.alu == OP_TEMP) && ok_d) begin
        held_q <= temp_d[HeldW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      d1_q <= s_axis_tdata[23:0];
      d2_q <= s_axis_tdata[47:24];
    end
    if (ctl.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctl.alu == OP_DT) begin
      dt_q <= dt_d;
    end
    if (ctl.alu == OP_TEMP) begin
      temp_q <= temp_d;
      ok_q   <= ok_d;
    end
    if (ctl.alu == OP_OFF) begin
      off_q <= off_d;
    end
    if (ctl.alu == OP_SENS) begin
      sens_q <= sens_d;
    end
    acc_q <= acc_d;
    if (out_load) begin
      // both values stay far inside 32 bits, so sign extension is the clamp
      out_temp_q  <= {{(OutW-TempW){temp_q[TempW-1]}}, temp_q};
      out_held_q  <= held_q;
      out_ok_q    <= ok_q;
      out_press_q <= {{(OutW-27){press_diff[41]}}, press_diff[41:15]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {1'b0, out_press_q, out_held_q, out_temp_q};

  // checks
  a_rise_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(step_q == STEP_OUT))
    else $error("result valid without a final step");

  a_held_on_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(held_q) |-> $past(ctl.alu == OP_TEMP))
    else $error("held temperature changed outside its step");

  a_held_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q > -15'sd3000) && (held_q < 15'sd10000))
    else $error("held temperature outside the window");

  a_start_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (step_q == step_t'(1)))
    else $error("sequencer did not start after an input request");

endmodule
